/* hw/rtl/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the WebSocket frame deframer.
// Holds the parse phase encoding, error codes and fragment kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0   = 3'd0,
      PH_HDR1   = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_MASK   = 3'd3,
      PH_DATA   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_RESERVED = 2'd1,
      ERR_UNMASKED = 2'd2,
      ERR_TOO_LONG = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      SLICE_WHOLE  = 2'd0,
      SLICE_FIRST  = 2'd1,
      SLICE_MIDDLE = 2'd2,
      SLICE_LAST   = 2'd3
   } slice_type;

   localparam logic [1:0] CSR_IS_CLIENT   = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd1;

   localparam logic [6:0]  LEN7_MAX_SHORT   = 7'd125;
   localparam logic [6:0]  LEN7_CODE_16     = 7'd126;
   localparam logic [3:0]  EXT_BYTES_16     = 4'd2;
   localparam logic [3:0]  EXT_BYTES_64     = 4'd8;
   localparam logic [31:0] MAX_PAYLOAD_INIT = 32'd1048576;

endpackage : wsfd_pkg

/* hw/rtl/websocket_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit: WebSocket receive-side frame parser.
// An accepted byte's result enters the output register at the next clock edge.
// One byte per cycle unless stalled; the output register is the only stage.
// Synchronous reset returns to the first header byte and clears the halt flag.
// The masking key store has no reset and is written before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_byte_present,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_fin,
   output logic [1:0]  rsp_slice_kind,
   output logic        rsp_last,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic                is_client_ff;
   logic [31:0]         max_len_ff;
   wsfd_pkg::phase_type phase_ff, phase_in;
   logic                fin_ff, fin_in;
   logic [3:0]          opcode_ff, opcode_in;
   logic                masked_ff, masked_in;
   logic [3:0]          ext_left_ff, ext_left_in;
   logic [63:0]         remaining_ff, remaining_in;
   logic [1:0]          key_idx_ff, key_idx_in;
   logic                halted_ff, halted_in;
   logic [7:0]          mask_key_ff [4];
   logic                key_we;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          payload_ff;
   logic                present_ff;
   logic [3:0]          opcode_out_ff;
   logic                fin_out_ff;
   logic [1:0]          slice_ff;
   logic                last_ff;
   logic [1:0]          err_out_ff;

   logic                req_accept;
   logic                out_free;
   logic                emit;
   logic                len_done;
   wsfd_pkg::err_type   err;
   logic [7:0]          emit_byte;
   logic                emit_present;
   logic                emit_last;
   wsfd_pkg::slice_type slice_cur;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !out_free;
   assign req_accept = req_valid && out_free;

   always_comb begin
      if (!fin_ff && opcode_ff != 4'd0) begin
         slice_cur = wsfd_pkg::SLICE_FIRST;
      end else if (!fin_ff) begin
         slice_cur = wsfd_pkg::SLICE_MIDDLE;
      end else if (opcode_ff == 4'd0) begin
         slice_cur = wsfd_pkg::SLICE_LAST;
      end else begin
         slice_cur = wsfd_pkg::SLICE_WHOLE;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      ext_left_in  = ext_left_ff;
      remaining_in = remaining_ff;
      key_idx_in   = key_idx_ff;
      halted_in    = halted_ff;
      key_we       = 1'b0;
      emit         = 1'b0;
      len_done     = 1'b0;
      err          = wsfd_pkg::ERR_NONE;
      emit_byte    = 8'd0;
      emit_present = 1'b0;
      emit_last    = 1'b0;

      if (req_accept && !halted_ff) begin
         case (phase_ff)
            wsfd_pkg::PH_HDR1: begin
               masked_in = req_rx_byte[7];
               if (!is_client_ff && !req_rx_byte[7]) begin
                  err = wsfd_pkg::ERR_UNMASKED;
               end else if (req_rx_byte[6:0] <= wsfd_pkg::LEN7_MAX_SHORT) begin
                  remaining_in = {57'd0, req_rx_byte[6:0]};
                  len_done     = 1'b1;
               end else begin
                  remaining_in = 64'd0;
                  ext_left_in  = (req_rx_byte[6:0] == wsfd_pkg::LEN7_CODE_16) ?
                                 wsfd_pkg::EXT_BYTES_16 : wsfd_pkg::EXT_BYTES_64;
                  phase_in     = wsfd_pkg::PH_EXTLEN;
               end
            end
            wsfd_pkg::PH_EXTLEN: begin
               remaining_in = {remaining_ff[55:0], req_rx_byte};
               ext_left_in  = ext_left_ff - 4'd1;
               len_done     = (ext_left_ff == 4'd1);
            end
            wsfd_pkg::PH_MASK: begin
               key_we     = 1'b1;
               key_idx_in = key_idx_ff + 2'd1;
               if (key_idx_ff == 2'd3) begin
                  if (remaining_ff == 64'd0) begin
                     phase_in  = wsfd_pkg::PH_HDR0;
                     emit      = 1'b1;
                     emit_last = 1'b1;
                  end else begin
                     phase_in = wsfd_pkg::PH_DATA;
                  end
               end
            end
            wsfd_pkg::PH_DATA: begin
               emit         = 1'b1;
               emit_present = 1'b1;
               emit_byte    = masked_ff ? (req_rx_byte ^ mask_key_ff[key_idx_ff]) :
                              req_rx_byte;
               key_idx_in   = key_idx_ff + 2'd1;
               remaining_in = remaining_ff - 64'd1;
               emit_last    = (remaining_ff == 64'd1);
               if (remaining_ff == 64'd1) begin
                  phase_in = wsfd_pkg::PH_HDR0;
               end
            end
            default: begin
               if (req_rx_byte[6:4] != 3'd0) begin
                  err = wsfd_pkg::ERR_RESERVED;
               end else begin
                  fin_in    = req_rx_byte[7];
                  opcode_in = req_rx_byte[3:0];
                  phase_in  = wsfd_pkg::PH_HDR1;
               end
            end
         endcase

         if (len_done) begin
            if (remaining_in[63:32] != 32'd0 || remaining_in[31:0] > max_len_ff) begin
               err = wsfd_pkg::ERR_TOO_LONG;
            end else begin
               key_idx_in = 2'd0;
               if (masked_in) begin
                  phase_in = wsfd_pkg::PH_MASK;
               end else if (remaining_in == 64'd0) begin
                  phase_in  = wsfd_pkg::PH_HDR0;
                  emit      = 1'b1;
                  emit_last = 1'b1;
               end else begin
                  phase_in = wsfd_pkg::PH_DATA;
               end
            end
         end

         if (err != wsfd_pkg::ERR_NONE) begin
            emit      = 1'b1;
            halted_in = 1'b1;
         end
      end

      if (out_free) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_client_ff <= 1'b0;
         max_len_ff   <= wsfd_pkg::MAX_PAYLOAD_INIT;
      end else if (csr_wr_en) begin
         if (csr_index == wsfd_pkg::CSR_IS_CLIENT) begin
            is_client_ff <= csr_wdata[0];
         end else if (csr_index == wsfd_pkg::CSR_MAX_PAYLOAD) begin
            max_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wsfd_pkg::PH_HDR0;
         fin_ff       <= 1'b0;
         opcode_ff    <= 4'd0;
         masked_ff    <= 1'b0;
         ext_left_ff  <= 4'd0;
         remaining_ff <= 64'd0;
         key_idx_ff   <= 2'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
         ext_left_ff  <= ext_left_in;
         remaining_ff <= remaining_in;
         key_idx_ff   <= key_idx_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         mask_key_ff[key_idx_ff] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         if (err != wsfd_pkg::ERR_NONE) begin
            payload_ff    <= 8'd0;
            present_ff    <= 1'b0;
            opcode_out_ff <= 4'd0;
            fin_out_ff    <= 1'b0;
            slice_ff      <= wsfd_pkg::SLICE_WHOLE;
            last_ff       <= 1'b0;
         end else begin
            payload_ff    <= emit_byte;
            present_ff    <= emit_present;
            opcode_out_ff <= opcode_ff;
            fin_out_ff    <= fin_ff;
            slice_ff      <= slice_cur;
            last_ff       <= emit_last;
         end
         err_out_ff <= err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_byte_present = present_ff;
   assign rsp_opcode       = opcode_out_ff;
   assign rsp_fin          = fin_out_ff;
   assign rsp_slice_kind   = slice_ff;
   assign rsp_last         = last_ff;
   assign rsp_error_code   = err_out_ff;

   // An error transfer is only ever presented once the parser has halted.
   a_err_halts : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_out_ff != wsfd_pkg::ERR_NONE |-> halted_ff)
      else $error("error result shown without halt");

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_byte_no_err : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && present_ff |-> err_out_ff == wsfd_pkg::ERR_NONE)
      else $error("payload byte carries an error code");

   a_halt_quiet : assert property (@(posedge clock) disable iff (reset)
      halted_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result produced after halt");

endmodule : websocket_frame_deframer_unit
